/* design/sacl_pkg.sv */
`timescale 1ns / 1ps

package sacl_pkg;

    localparam int ADDR_W     = 32;
    localparam int NUM_WAYS   = 8;
    localparam int NUM_SETS   = 256;
    localparam int SET_W      = 8;
    localparam int WAY_W      = 3;
    localparam int AGE_W      = 3;
    localparam int CNT_W      = 4;
    localparam int CFG_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int SHIFT_W    = 5;
    localparam int OUT_W      = 48;

    localparam logic [CFG_W-1:0] OFFSET_CAP    = 4'd12;
    localparam logic [CFG_W-1:0] SET_CAP       = 4'd8;
    localparam logic [CFG_W-1:0] WAYS_MIN      = 4'd1;
    localparam logic [CFG_W-1:0] WAYS_MAX      = 4'd8;
    localparam logic [CFG_W-1:0] OFFSET_RESET  = 4'd4;
    localparam logic [CFG_W-1:0] SET_RESET     = 4'd6;
    localparam logic [CFG_W-1:0] WAYS_RESET    = 4'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

    typedef struct packed {
        logic [NUM_WAYS-1:0]             valid;
        logic [NUM_WAYS-1:0][AGE_W-1:0]  age;
        logic [NUM_WAYS-1:0][ADDR_W-1:0] tag;
    } t_row;

    typedef struct packed {
        logic load;
        logic commit;
    } t_cmd;

endpackage

/* design/set_assoc_cache_lru_lookup.sv */
`timescale 1ns / 1ps

// tag directory of a set-associative cache with true lru replacement
// input stream: s_axis_tdata carries one 32-bit byte address per transaction
// output stream: one result per address: hit, set, way, eviction flag and tag
// config port: i_cfg_we, i_cfg_idx (0 offset_bits, 1 set_bits, 2 ways_in_use),
//   i_cfg_data; write only while no transaction is in flight
// the set row is registered when an address is taken and the result is
//   registered when the lookup commits; the idle state reads the set row
//   from the directory ram, the lookup state compares all ways, updates ages
//   and writes the row back over the single ram port pair, one lookup at a time
// the input side is taken again while a result still waits on the output
//   register; if the receiver stalls, the next lookup waits in the lookup
//   state until the output register frees, and tready stays low meanwhile
// reset: synchronous, active low; config returns to 4/6/4 and every set
//   reads empty at once through per-set live flags, no clearing pass
module set_assoc_cache_lru_lookup (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [31:0] address
    input  logic [sacl_pkg::ADDR_W-1:0]          s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [0] hit, [8:1] set_index, [11:9] way, [12] evicted, [44:13] evicted_tag,
    // [47:45] zero
    output logic [sacl_pkg::OUT_W-1:0]           m_axis_tdata,
    input  logic                                 i_cfg_we,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [sacl_pkg::CFG_W-1:0]           i_cfg_data
);
    import sacl_pkg::*;

    t_cmd              cmd;
    logic              hit;
    logic [SET_W-1:0]  set_index;
    logic [WAY_W-1:0]  way;
    logic              evicted;
    logic [ADDR_W-1:0] evicted_tag;

    sacl_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .o_cmd     (cmd)
    );

    sacl_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_address     (s_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_hit         (hit),
        .o_set_index   (set_index),
        .o_way         (way),
        .o_evicted     (evicted),
        .o_evicted_tag (evicted_tag)
    );

    assign m_axis_tdata = {3'b000, evicted_tag, evicted, way, set_index, hit};

`ifndef SYNTH
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while a lookup is in flight");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(hit && evicted))
        else $error("hit reported together with eviction");

    a_tag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !evicted) |-> (evicted_tag == '0))
        else $error("evicted tag non-zero without eviction");
`endif

endmodule

/* design/sacl_ctrl.sv */
`timescale 1ns / 1ps

module sacl_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_valid,
    input  logic          i_m_ready,
    output logic          o_s_ready,
    output logic          o_m_valid,
    output sacl_pkg::t_cmd o_cmd
);
    import sacl_pkg::*;

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_LOOKUP = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic out_free;

    assign out_free  = !r_out_valid || i_m_ready;
    assign o_s_ready = (r_state == ST_IDLE);
    assign o_m_valid = r_out_valid;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_m_ready;
        case (r_state)
            ST_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* design/sacl_datapath.sv */
`timescale 1ns / 1ps

module sacl_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  sacl_pkg::t_cmd                     i_cmd,
    input  logic [sacl_pkg::ADDR_W-1:0]        i_address,
    input  logic                               i_cfg_we,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sacl_pkg::CFG_W-1:0]         i_cfg_data,
    output logic                               o_hit,
    output logic [sacl_pkg::SET_W-1:0]         o_set_index,
    output logic [sacl_pkg::WAY_W-1:0]         o_way,
    output logic                               o_evicted,
    output logic [sacl_pkg::ADDR_W-1:0]        o_evicted_tag
);
    import sacl_pkg::*;

    // configuration
    logic [CFG_W-1:0] r_offset_bits, r_set_bits, r_ways_in_use;

    // tag, age and valid directory, one row per set
    t_row mem [NUM_SETS];
    t_row r_rd;
    logic [NUM_SETS-1:0] r_row_live;
    logic r_live;

    // item held for the lookup
    logic [SET_W-1:0]  r_set;
    logic [ADDR_W-1:0] r_tag;
    logic [CFG_W-1:0]  r_ways;

    // accept side
    logic [CFG_W-1:0]   ob, sb, wu;
    logic [ADDR_W-1:0]  shifted;
    logic [SET_W:0]     set_mask;
    logic [SHIFT_W-1:0] tag_shift;
    logic [SET_W-1:0]   in_set;
    logic [ADDR_W-1:0]  in_tag;

    // lookup side
    logic [NUM_WAYS-1:0] valid, valid_upd;
    logic                found, any_valid, free_found, is_hit, do_evict;
    logic [WAY_W-1:0]    hit_way, free_way, lru_way, target;
    logic [AGE_W-1:0]    oldest, hit_age;
    logic [CNT_W-1:0]    count;
    t_row                n_row;

    always_comb begin
        ob        = (r_offset_bits > OFFSET_CAP) ? OFFSET_CAP : r_offset_bits;
        sb        = (r_set_bits > SET_CAP) ? SET_CAP : r_set_bits;
        wu        = (r_ways_in_use < WAYS_MIN) ? WAYS_MIN :
                    ((r_ways_in_use > WAYS_MAX) ? WAYS_MAX : r_ways_in_use);
        shifted   = i_address >> ob;
        set_mask  = ({{SET_W{1'b0}}, 1'b1} << sb) - {{SET_W{1'b0}}, 1'b1};
        in_set    = shifted[SET_W-1:0] & set_mask[SET_W-1:0];
        tag_shift = {1'b0, ob} + {1'b0, sb};
        in_tag    = i_address >> tag_shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_bits <= OFFSET_RESET;
            r_set_bits    <= SET_RESET;
            r_ways_in_use <= WAYS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OFFSET_BITS: r_offset_bits <= i_cfg_data;
                CFG_SET_BITS:    r_set_bits    <= i_cfg_data;
                CFG_WAYS_IN_USE: r_ways_in_use <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        valid      = r_live ? r_rd.valid : '0;
        found      = 1'b0;
        hit_way    = '0;
        hit_age    = '0;
        free_found = 1'b0;
        free_way   = '0;
        any_valid  = 1'b0;
        oldest     = '0;
        lru_way    = '0;
        count      = '0;
        for (int k = 0; k < NUM_WAYS; k++) begin
            if (valid[k]) begin
                count = count + 1'b1;
                if (!found && r_rd.tag[k] == r_tag) begin
                    found   = 1'b1;
                    hit_way = WAY_W'(k);
                    hit_age = r_rd.age[k];
                end
                if (!any_valid || r_rd.age[k] > oldest) begin
                    any_valid = 1'b1;
                    oldest    = r_rd.age[k];
                    lru_way   = WAY_W'(k);
                end
            end else if (!free_found) begin
                free_found = 1'b1;
                free_way   = WAY_W'(k);
            end
        end
        is_hit   = found;
        do_evict = !found && !(count < r_ways);
        target   = found ? hit_way : (do_evict ? lru_way : free_way);

        valid_upd = valid;
        if (do_evict) begin
            valid_upd[target] = 1'b0;
        end
        n_row       = r_rd;
        n_row.valid = valid_upd;
        for (int k = 0; k < NUM_WAYS; k++) begin
            if (valid_upd[k] &&
                (is_hit ? (r_rd.age[k] < hit_age) : (r_rd.age[k] != '1))) begin
                n_row.age[k] = r_rd.age[k] + 1'b1;
            end
        end
        n_row.valid[target] = 1'b1;
        n_row.age[target]   = '0;
        if (!is_hit) begin
            n_row.tag[target] = r_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd <= mem[in_set];
        end
        if (i_cmd.commit) begin
            mem[r_set] <= n_row;
        end
    end

    // a row never written reads as all ways invalid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_live <= '0;
        end else if (i_cmd.commit) begin
            r_row_live[r_set] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_set  <= in_set;
            r_tag  <= in_tag;
            r_ways <= wu;
            r_live <= r_row_live[in_set];
        end
        if (i_cmd.commit) begin
            o_hit         <= is_hit;
            o_set_index   <= r_set;
            o_way         <= target;
            o_evicted     <= do_evict;
            o_evicted_tag <= do_evict ? r_rd.tag[target] : '0;
        end
    end

endmodule

/* verif/set_assoc_cache_lru_lookup_checker.sv */
`timescale 1ns / 1ps

module set_assoc_cache_lru_lookup_checker
    import sacl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [ADDR_W-1:0]    i_s_tdata,
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [OUT_W-1:0]     i_m_tdata,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic [ADDR_W-1:0] evicted_tag;
        logic              evicted;
        logic [WAY_W-1:0]  way;
        logic [SET_W-1:0]  set_index;
        logic              hit;
    } t_lookup;

    logic [CFG_W-1:0]  offset_bits;
    logic [CFG_W-1:0]  set_bits;
    logic [CFG_W-1:0]  ways_in_use;
    logic              line_valid [NUM_SETS][NUM_WAYS];
    logic [ADDR_W-1:0] line_tag   [NUM_SETS][NUM_WAYS];
    logic [AGE_W-1:0]  line_age   [NUM_SETS][NUM_WAYS];
    t_lookup           expected_lookups [$];
    t_lookup           want;
    t_lookup           got;
    int                fail_count = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic t_lookup lru_lookup(input logic [ADDR_W-1:0] addr);
        int                ob;
        int                sb;
        int                nw;
        int                s;
        int                count;
        int                target;
        logic              found;
        logic              any;
        logic [AGE_W-1:0]  a;
        logic [AGE_W-1:0]  oldest;
        logic [ADDR_W-1:0] t;
        t_lookup           r;
        ob = int'((offset_bits > OFFSET_CAP) ? OFFSET_CAP : offset_bits);
        sb = int'((set_bits > SET_CAP) ? SET_CAP : set_bits);
        nw = int'((ways_in_use < WAYS_MIN) ? WAYS_MIN :
                  (ways_in_use > WAYS_MAX) ? WAYS_MAX : ways_in_use);
        s = ((addr >> ob) & ((32'd1 << sb) - 32'd1)) % NUM_SETS;
        t = addr >> (ob + sb);
        r = '0;
        r.set_index = s[SET_W-1:0];
        count  = 0;
        target = 0;
        found  = 1'b0;
        for (int k = 0; k < NUM_WAYS; k++) begin
            if (line_valid[s][k]) begin
                count++;
                if (!found && line_tag[s][k] == t) begin
                    found  = 1'b1;
                    target = k;
                end
            end
        end
        if (found) begin
            a = line_age[s][target];
            r.hit = 1'b1;
            for (int k = 0; k < NUM_WAYS; k++)
                if (line_valid[s][k] && line_age[s][k] < a)
                    line_age[s][k]++;
            line_age[s][target] = '0;
        end else begin
            if (count < nw) begin
                for (int k = NUM_WAYS - 1; k >= 0; k--)
                    if (!line_valid[s][k])
                        target = k;
            end else begin
                // replace the least recently used valid way, lowest on a tie
                any    = 1'b0;
                oldest = '0;
                for (int k = 0; k < NUM_WAYS; k++) begin
                    if (line_valid[s][k] && (!any || line_age[s][k] > oldest)) begin
                        oldest = line_age[s][k];
                        target = k;
                        any    = 1'b1;
                    end
                end
                r.evicted     = 1'b1;
                r.evicted_tag = line_tag[s][target];
                line_valid[s][target] = 1'b0;
            end
            for (int k = 0; k < NUM_WAYS; k++)
                if (line_valid[s][k] && line_age[s][k] < 3'd7)
                    line_age[s][k]++;
            line_valid[s][target] = 1'b1;
            line_tag[s][target]   = t;
            line_age[s][target]   = '0;
        end
        r.way = target[WAY_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [ADDR_W-1:0] exp_v,
                               input logic [ADDR_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s expected %h got %h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            offset_bits = OFFSET_RESET;
            set_bits    = SET_RESET;
            ways_in_use = WAYS_RESET;
            for (int s = 0; s < NUM_SETS; s++) begin
                for (int k = 0; k < NUM_WAYS; k++) begin
                    line_valid[s][k] = 1'b0;
                    line_tag[s][k]   = '0;
                    line_age[s][k]   = '0;
                end
            end
            expected_lookups.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                expected_lookups = {expected_lookups, lru_lookup(i_s_tdata)};
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_OFFSET_BITS: offset_bits = i_cfg_data;
                    CFG_SET_BITS:    set_bits    = i_cfg_data;
                    CFG_WAYS_IN_USE: ways_in_use = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_lookups.size() == 0) begin
                    $display("%0t: result with none expected, got %h", $time, i_m_tdata);
                    fail_count++;
                end else begin
                    want = expected_lookups.pop_front();
                    got  = i_m_tdata[$bits(t_lookup)-1:0];
                    check_field("hit", ADDR_W'(want.hit), ADDR_W'(got.hit));
                    check_field("set_index", ADDR_W'(want.set_index),
                                ADDR_W'(got.set_index));
                    check_field("way", ADDR_W'(want.way), ADDR_W'(got.way));
                    check_field("evicted", ADDR_W'(want.evicted), ADDR_W'(got.evicted));
                    check_field("evicted_tag", want.evicted_tag, got.evicted_tag);
                    check_field("padding", '0,
                                ADDR_W'(i_m_tdata[OUT_W-1:$bits(t_lookup)]));
                end
            end
        end
        o_pending    <= expected_lookups.size();
        o_fail_count <= fail_count;
    end

endmodule

/* verif/set_assoc_cache_lru_lookup_tb.sv */
`timescale 1ns / 1ps

module set_assoc_cache_lru_lookup_tb;
    import sacl_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TAG_POOL    = 10;
    localparam int NUM_PHASES  = 9;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [ADDR_W-1:0]    s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_OFFSET_BITS;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    int                   fail_count;
    int                   pending;
    int                   cycle_count = 0;
    int                   burst_left = 1;
    int                   cur_ob = int'(OFFSET_RESET);
    int                   cur_sb = int'(SET_RESET);
    logic [ADDR_W-1:0]    addr_tags [TAG_POOL];

    always #4 i_clk = ~i_clk;

    set_assoc_cache_lru_lookup dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    set_assoc_cache_lru_lookup_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: stall pattern in segments, with a long hold-off after 150 results, then every 500
    initial begin
        int seg;
        int mode;
        int hold;
        int results_seen;
        int next_hold;
        seg          = 0;
        mode         = 0;
        hold         = 0;
        results_seen = 0;
        next_hold    = 150;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready)
                results_seen++;
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else if (results_seen >= next_hold) begin
                hold      = 400;
                next_hold = next_hold + 500;
                m_axis_tready <= 1'b0;
            end else begin
                if (seg == 0) begin
                    seg  = $urandom_range(20, 120);
                    mode = $urandom_range(0, 2);
                end
                seg--;
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic send_addr(input logic [ADDR_W-1:0] addr);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= addr;
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    task automatic write_regs(input int ob, input int sb, input int nw);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_OFFSET_BITS;
        i_cfg_data <= CFG_W'(ob);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SET_BITS;
        i_cfg_data <= CFG_W'(sb);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_WAYS_IN_USE;
        i_cfg_data <= CFG_W'(nw);
        @(posedge i_clk);
        // index past the register list, ignored by the block
        i_cfg_idx  <= CFG_IDX_W'(CFG_WAYS_IN_USE + 1);
        i_cfg_data <= CFG_W'($urandom);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_ob = (ob > int'(OFFSET_CAP)) ? int'(OFFSET_CAP) : ob;
        cur_sb = (sb > int'(SET_CAP)) ? int'(SET_CAP) : sb;
        for (int k = 0; k < TAG_POOL; k++)
            addr_tags[k] = $urandom;
    endtask

    function automatic logic [ADDR_W-1:0] pick_addr();
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] set_mask;
        logic [ADDR_W-1:0] set_sel;
        set_mask = (32'd1 << cur_sb) - 32'd1;
        if ($urandom_range(0, 99) < 10)
            return $urandom;
        set_sel = ($urandom_range(0, 4) == 4) ? set_mask : $urandom_range(0, 3);
        a = addr_tags[$urandom_range(0, TAG_POOL - 1)] << (cur_ob + cur_sb);
        a = a | ((set_sel & set_mask) << cur_ob);
        a = a | ($urandom & ((32'd1 << cur_ob) - 32'd1));
        return a;
    endfunction

    initial begin
        int phase_ob [NUM_PHASES];
        int phase_sb [NUM_PHASES];
        int phase_nw [NUM_PHASES];
        int phase_n  [NUM_PHASES];
        logic [ADDR_W-1:0] directed [$];

        phase_ob = '{0, 12, 15, 15, 2, 2, 0, 0, 0};
        phase_sb = '{0, 8, 15, 15, 3, 3, 0, 0, 0};
        phase_nw = '{1, 8, 0, 15, 8, 2, 0, 0, 0};
        phase_n  = '{100, 150, 100, 100, 150, 150, 80, 80, 80};
        for (int p = 6; p < NUM_PHASES; p++) begin
            phase_ob[p] = $urandom_range(0, 15);
            phase_sb[p] = $urandom_range(0, 15);
            phase_nw[p] = $urandom_range(0, 15);
        end

        // reset layout: offset 4, set 6, four ways; set 0 fills then evicts
        directed = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_000F,
                     32'h0000_0400, 32'h0000_0800, 32'h0000_0C00, 32'h0000_0000,
                     32'h0000_1000, 32'h0000_0400, 32'hFFFF_FFFF, 32'h8000_0000,
                     32'hFFFF_FC00, 32'h0000_03F0, 32'hAAAA_AAAA, 32'h5555_5555,
                     32'h0000_0C05, 32'h0000_1000, 32'h0000_0800, 32'hFFFF_FFF0};
        for (int k = 0; k < TAG_POOL; k++)
            addr_tags[k] = $urandom;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i])
            send_addr(directed[i]);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_regs(phase_ob[p], phase_sb[p], phase_nw[p]);
            for (int n = 0; n < phase_n[p]; n++)
                send_addr(pick_addr());
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
